// ===== rtl/fbfl_pkg.sv =====
// Shared constants, codes and types for the fixed block free list allocator.
// No dependencies; all other files of the block but fbfl_queue import it.
package fbfl_pkg;

   localparam int ADDR_PORT_W = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int LIVE_W      = 9;
   localparam int BLK_W       = 17;
   localparam int COUNT_W     = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int KIND_W      = 2;

   localparam logic [BLK_W-1:0]   MIN_BLOCK_BYTES = 17'd16;
   localparam logic [BLK_W-1:0]   BLK_RESET       = 17'd16;
   localparam logic [COUNT_W-1:0] COUNT_RESET     = 9'd256;

   // request operations
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_MISALIGN  = 3'd4;

   // work kinds handed from the front end to the back end
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELINK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REPORT = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POOL_BASE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
   } fbfl_cmd_type;

   // pool base and effective (clamped) block size
   typedef struct packed {
      logic [ADDR_PORT_W-1:0] pool_base;
      logic [BLK_W-1:0]       block_bytes;
   } fbfl_cfg_type;

endpackage

// ===== rtl/fbfl_if.sv =====
// Request and response channel interfaces of the free list allocator.
// Depends on fbfl_pkg for the payload widths.
interface fbfl_req_if;
   import fbfl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [ADDR_PORT_W-1:0] release_address;

   modport source (output valid, output operation, output release_address, input ready);
   modport sink   (input valid, input operation, input release_address, output ready);
endinterface

interface fbfl_rsp_if;
   import fbfl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ADDR_PORT_W-1:0] block_address;
   logic [STATUS_W-1:0]    status;
   logic [LIVE_W-1:0]      live_count;

   modport source (output valid, output block_address, output status, output live_count,
                   input ready);
   modport sink   (input valid, input block_address, input status, input live_count,
                   output ready);
endinterface

// ===== rtl/fbfl_queue.sv =====
// Two-entry queue between the front end and the back end of the allocator.
// Depends on nothing beyond its width parameter.
module fbfl_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = 2;
   localparam int PTRW  = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNTW'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTRW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTRW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = CNTW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CNTW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/fbfl_front.sv =====
// Front end: takes requests, checks free addresses against the pool span
// and queues the work. Depends on fbfl_pkg and fbfl_if.
module fbfl_front #(
   parameter int MAX_BLOCKS = 256,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   fbfl_req_if.sink                                             req_ch,
   input  fbfl_pkg::fbfl_cfg_type                               cfg,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]                      eff_count,
   input  logic                                                 cfg_write,
   input  logic                                                 q_full,
   output logic                                                 q_push,
   output fbfl_pkg::fbfl_cmd_type                               q_cmd,
   output logic [fbfl_pkg::BLK_W+$clog2(MAX_BLOCKS+1)-1:0]      q_offset
);
   import fbfl_pkg::*;

   localparam int LINKW = $clog2(MAX_BLOCKS + 1);
   localparam int SPANW = BLK_W + LINKW;
   localparam int CMPW  = (ADDR_WIDTH > SPANW) ? ADDR_WIDTH : SPANW;

   logic                   stg_valid_ff, stg_valid_in;
   logic [OP_W-1:0]        stg_op_ff;
   logic [ADDR_PORT_W-1:0] stg_addr_ff;
   logic [SPANW-1:0]       span_ff, span_in;
   logic                   stale_ff;
   logic [ADDR_WIDTH-1:0]  offset;
   logic                   in_range;
   logic                   accept;

   // registered span lags a register write: hold the stage until it settles
   assign q_push       = stg_valid_ff && !q_full && !stale_ff;
   assign req_ch.ready = !stg_valid_ff || q_push;
   assign accept       = req_ch.valid && req_ch.ready;
   assign stg_valid_in = accept || (stg_valid_ff && !q_push);

   assign span_in  = {{LINKW{1'b0}}, cfg.block_bytes} * {{BLK_W{1'b0}}, eff_count};
   assign offset   = ADDR_WIDTH'(stg_addr_ff) - ADDR_WIDTH'(cfg.pool_base);
   assign in_range = CMPW'(offset) < CMPW'(span_ff);
   assign q_offset = SPANW'(offset);

   always_comb begin
      q_cmd.kind   = KIND_REPORT;
      q_cmd.status = STATUS_OK;
      case (stg_op_ff)
         OP_ALLOC: begin
            q_cmd.kind = KIND_ALLOC;
         end
         OP_FREE: begin
            if (stg_addr_ff == '0) begin
               q_cmd.status = STATUS_NULL;
            end else if (!in_range) begin
               q_cmd.status = STATUS_RANGE;
            end else begin
               q_cmd.kind = KIND_PUSH;
            end
         end
         OP_RESET: begin
            q_cmd.kind = KIND_RELINK;
         end
         default: begin
            q_cmd.kind = KIND_REPORT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         stale_ff     <= 1'b1;
      end else begin
         stg_valid_ff <= stg_valid_in;
         stale_ff     <= cfg_write;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      if (accept) begin
         stg_op_ff   <= req_ch.operation;
         stg_addr_ff <= req_ch.release_address;
      end
   end

endmodule

// ===== rtl/fbfl_div.sv =====
// Restoring divider: block index and exactness of a pool offset, one
// quotient bit per cycle. Depends on fbfl_pkg.
module fbfl_div #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   input  logic [fbfl_pkg::BLK_W+$clog2(MAX_BLOCKS+1)-1:0] num,
   input  logic [fbfl_pkg::BLK_W-1:0]                      den,
   output logic                                            done,
   output logic                                            exact,
   output logic [$clog2(MAX_BLOCKS)-1:0]                   quot
);
   import fbfl_pkg::*;

   localparam int IDXW  = $clog2(MAX_BLOCKS);
   localparam int LINKW = $clog2(MAX_BLOCKS + 1);
   localparam int SPANW = BLK_W + LINKW;
   localparam int SW    = (IDXW > 1) ? $clog2(IDXW) : 1;

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [SPANW-1:0] rem_ff, rem_in;
   logic [SPANW-1:0] trial_ff, trial_in;
   logic [IDXW-1:0]  quot_ff, quot_in;
   logic             fits;

   assign fits  = (rem_ff >= trial_ff);
   assign done  = done_ff;
   assign exact = (rem_ff == '0);
   assign quot  = quot_ff;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      trial_in  = trial_ff;
      quot_in   = quot_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = SW'(IDXW - 1);
         rem_in    = num;
         trial_in  = {{LINKW{1'b0}}, den} << (IDXW - 1);
         quot_in   = '0;
      end else if (active_ff) begin
         if (fits) begin
            rem_in = rem_ff - trial_ff;
         end
         quot_in  = IDXW'(quot_ff << 1) | IDXW'(fits);
         trial_in = trial_ff >> 1;
         if (step_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            step_in = SW'(step_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      trial_ff <= trial_in;
      quot_ff  <= quot_in;
   end

endmodule

// ===== rtl/fbfl_back.sv =====
// Back end: owns the link store, list head and allocated count, executes
// queued work and drives the response register. Depends on fbfl_pkg,
// fbfl_if and fbfl_div.
module fbfl_back #(
   parameter int MAX_BLOCKS = 256,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  fbfl_pkg::fbfl_cfg_type                          cfg,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]                 eff_count,
   input  logic                                            q_valid,
   input  fbfl_pkg::fbfl_cmd_type                          q_cmd,
   input  logic [fbfl_pkg::BLK_W+$clog2(MAX_BLOCKS+1)-1:0] q_offset,
   output logic                                            q_pop,
   fbfl_rsp_if.source                                      rsp_ch
);
   import fbfl_pkg::*;

   localparam int IDXW  = $clog2(MAX_BLOCKS);
   localparam int LINKW = $clog2(MAX_BLOCKS + 1);
   localparam int PRODW = IDXW + BLK_W;
   localparam int RESET_N = (MAX_BLOCKS < int'(COUNT_RESET)) ? MAX_BLOCKS : int'(COUNT_RESET);
   localparam logic [LINKW-1:0] LIST_END = LINKW'(MAX_BLOCKS);
   localparam logic [LINKW-1:0] LAST_IDX = LINKW'(MAX_BLOCKS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ALLOC  = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_RELINK = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [LINKW-1:0]       head_ff, head_in;
   logic [LINKW-1:0]       total_ff, total_in;
   logic [LINKW-1:0]       ctr_ff, ctr_in;
   logic [LINKW-1:0]       relink_n_ff, relink_n_in;
   logic                   relink_rsp_ff, relink_rsp_in;
   logic [ADDR_PORT_W-1:0] res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_PORT_W-1:0] rsp_addr_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [LIVE_W-1:0]      rsp_live_ff;
   logic                   rsp_load;
   logic                   out_free;

   logic [LINKW-1:0]       link_mem [MAX_BLOCKS];
   logic [LINKW-1:0]       rd_data_ff;
   logic                   mem_we;
   logic [IDXW-1:0]        mem_waddr;
   logic [LINKW-1:0]       mem_wdata;

   logic [PRODW-1:0]       prod_ff;
   logic [ADDR_WIDTH-1:0]  alloc_sum;
   logic [LINKW-1:0]       ctr_next;
   logic                   head_empty;

   logic                   div_start;
   logic                   div_done;
   logic                   div_exact;
   logic [IDXW-1:0]        div_quot;

   fbfl_div #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (q_offset),
      .den   (cfg.block_bytes),
      .done  (div_done),
      .exact (div_exact),
      .quot  (div_quot)
   );

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign head_empty = (head_ff >= LIST_END);
   assign alloc_sum  = ADDR_WIDTH'(cfg.pool_base) + ADDR_WIDTH'(prod_ff);
   assign ctr_next   = LINKW'(ctr_ff + 1'b1);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.block_address = rsp_addr_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.live_count    = rsp_live_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      ctr_in        = ctr_ff;
      relink_n_in   = relink_n_ff;
      relink_rsp_in = relink_rsp_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = ctr_ff[IDXW-1:0];
      mem_wdata     = (ctr_next < relink_n_ff) ? ctr_next : LIST_END;
      div_start     = 1'b0;
      q_pop         = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               res_addr_in = '0;
               case (q_cmd.kind)
                  KIND_ALLOC: begin
                     if (head_empty) begin
                        res_status_in = STATUS_EXHAUSTED;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_ALLOC;
                     end
                  end
                  KIND_PUSH: begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
                  KIND_RELINK: begin
                     ctr_in        = '0;
                     relink_n_in   = eff_count;
                     relink_rsp_in = 1'b1;
                     state_in      = ST_RELINK;
                  end
                  default: begin
                     res_status_in = q_cmd.status;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            // pop the head: link word and product were read off the old head
            head_in       = rd_data_ff;
            res_addr_in   = ADDR_PORT_W'(alloc_sum);
            res_status_in = STATUS_OK;
            if (total_ff < LIST_END) begin
               total_in = LINKW'(total_ff + 1'b1);
            end
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_exact) begin
                  mem_we        = 1'b1;
                  mem_waddr     = div_quot;
                  mem_wdata     = head_ff;
                  head_in       = LINKW'(div_quot);
                  res_status_in = STATUS_OK;
                  if (total_ff != '0) begin
                     total_in = LINKW'(total_ff - 1'b1);
                  end
               end else begin
                  res_status_in = STATUS_MISALIGN;
               end
               state_in = ST_DONE;
            end
         end
         ST_RELINK: begin
            mem_we = 1'b1;
            ctr_in = ctr_next;
            if (ctr_ff == LAST_IDX) begin
               head_in       = '0;
               total_in      = '0;
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
               relink_rsp_in = 1'b0;
               state_in      = relink_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RELINK;
         head_ff       <= '0;
         total_ff      <= '0;
         ctr_ff        <= '0;
         relink_n_ff   <= LINKW'(RESET_N);
         relink_rsp_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         ctr_ff        <= ctr_in;
         relink_n_ff   <= relink_n_in;
         relink_rsp_ff <= relink_rsp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      prod_ff       <= {{IDXW{1'b0}}, cfg.block_bytes} * {{BLK_W{1'b0}}, head_ff[IDXW-1:0]};
      if (rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
         rsp_live_ff   <= LIVE_W'(total_ff);
      end
   end

   // link store: one write port, registered read at the list head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= link_mem[head_ff[IDXW-1:0]];
   end

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LIST_END)
      else $error("list head beyond end mark");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= LIST_END)
      else $error("allocated count above pool capacity");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (total_ff == $past(total_ff) || total_ff == '0 ||
                         total_ff == LINKW'($past(total_ff) + 1'b1) ||
                         total_ff == LINKW'($past(total_ff) - 1'b1)))
      else $error("allocated count moved by more than one");

   a_done_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished request did not reach the response register");

endmodule

// ===== rtl/fixed_block_free_list_allocator.sv =====
// Fixed-size block pool with a last-in-first-out free list threaded through a
// link store of MAX_BLOCKS entries. A request is registered in the front
// stage, where frees are range checked, and then waits in a two-entry queue
// for the back end, which owns the link store (one write port) and runs one
// request at a time. In the back end an allocate does a registered link
// read and index multiply, then the address add; a free runs the divider
// that yields the block index and the alignment check, which retires one
// bit a cycle; a pool reset, the relink, rewrites the whole store at one
// link-store write a cycle; null, out-of-range and unused requests go
// straight to the response.
// After reset the back end relinks the whole store before it serves the
// first request; requests and register writes are taken meanwhile. After
// a register write, a request in the front stage is held there while the
// pool span is recomputed.
module fixed_block_free_list_allocator #(
   parameter int MAX_BLOCKS = 256,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   fbfl_req_if.sink                            req_ch,
   fbfl_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [fbfl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbfl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fbfl_pkg::*;

   localparam int LINKW  = $clog2(MAX_BLOCKS + 1);
   localparam int SPANW  = BLK_W + LINKW;
   localparam int CMPC_W = (LINKW > COUNT_W) ? LINKW : COUNT_W;
   localparam int QW     = $bits(fbfl_cmd_type) + SPANW;

   logic [ADDR_PORT_W-1:0] pool_base_ff;
   logic [BLK_W-1:0]       block_bytes_ff;
   logic [COUNT_W-1:0]     blocks_in_use_ff;

   fbfl_cfg_type           cfg;
   logic [CMPC_W-1:0]      count_ext;
   logic [LINKW-1:0]       eff_count;

   logic                   f_push;
   fbfl_cmd_type           f_cmd;
   logic [SPANW-1:0]       f_offset;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;
   logic [QW-1:0]          q_head;
   fbfl_cmd_type           b_cmd;
   logic [SPANW-1:0]       b_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff     <= '0;
         block_bytes_ff   <= BLK_RESET;
         blocks_in_use_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_POOL_BASE:     pool_base_ff     <= csr_wdata;
            REG_BLOCK_BYTES:   block_bytes_ff   <= csr_wdata[BLK_W-1:0];
            REG_BLOCKS_IN_USE: blocks_in_use_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp block size up to the minimum and block count into 1..MAX_BLOCKS
   always_comb begin
      cfg.pool_base   = pool_base_ff;
      cfg.block_bytes = (block_bytes_ff < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES
                                                           : block_bytes_ff;
      count_ext = CMPC_W'(blocks_in_use_ff);
      if (count_ext == '0) begin
         eff_count = LINKW'(1);
      end else if (count_ext > CMPC_W'(MAX_BLOCKS)) begin
         eff_count = LINKW'(MAX_BLOCKS);
      end else begin
         eff_count = LINKW'(count_ext);
      end
   end

   fbfl_front #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg),
      .eff_count (eff_count),
      .cfg_write (csr_we),
      .q_full    (q_full),
      .q_push    (f_push),
      .q_cmd     (f_cmd),
      .q_offset  (f_offset)
   );

   fbfl_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_cmd, f_offset}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_head)
   );

   assign {b_cmd, b_offset} = q_head;

   fbfl_back #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .eff_count (eff_count),
      .q_valid   (q_valid),
      .q_cmd     (b_cmd),
      .q_offset  (b_offset),
      .q_pop     (q_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for fixed_block_free_list_allocator: directed and random requests,
// with a per-request predictor of the free list, checked against every response.
// Depends on fbfl_pkg, the fbfl_req_if/fbfl_rsp_if interfaces and the allocator RTL.
module tb;
   import fbfl_pkg::*;

   localparam int POOL_SLOTS  = 256;
   localparam int QUIET_LIMIT = 4000;
   localparam int PAUSE_CYCLES = 12;
   localparam int DRAIN_CYCLES = 300;

   localparam logic [OP_W-1:0]      OP_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]        operation;
      logic [ADDR_PORT_W-1:0] release_address;
   } pool_req_type;

   typedef struct packed {
      logic [ADDR_PORT_W-1:0] block_address;
      logic [STATUS_W-1:0]    status;
      logic [LIVE_W-1:0]      live_count;
   } pool_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   fbfl_req_if req_bus ();
   fbfl_rsp_if rsp_bus ();

   fixed_block_free_list_allocator #(
      .MAX_BLOCKS (POOL_SLOTS),
      .ADDR_WIDTH (ADDR_PORT_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // free list shadow and register copies
   logic [8:0]             next_free [POOL_SLOTS];
   logic [8:0]             free_head;
   logic [LIVE_W-1:0]      live_blocks;
   logic [ADDR_PORT_W-1:0] cfg_base;
   logic [BLK_W-1:0]       cfg_block;
   logic [COUNT_W-1:0]     cfg_count;

   pool_req_type   req_backlog [$];
   pool_rsp_type   due_results [$];
   pool_req_type   req_in_hand;
   pool_rsp_type   predicted_rsp;
   pool_rsp_type   oldest_due;
   int unsigned reqs_queued;
   int unsigned reqs_taken;
   int          burst_left;
   int          gap_left;
   int          mismatches;
   int          quiet_cycles;
   logic [15:0] stall_mask;
   logic [6:0]  stall_phase;

   function automatic logic [BLK_W-1:0] eff_block();
      return (cfg_block < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg_block;
   endfunction

   function automatic int unsigned eff_count();
      if (cfg_count == 0) return 1;
      if (cfg_count > POOL_SLOTS) return POOL_SLOTS;
      return cfg_count;
   endfunction

   function automatic logic [ADDR_PORT_W-1:0] block_at(input int unsigned k);
      return cfg_base + ADDR_PORT_W'(k) * ADDR_PORT_W'(eff_block());
   endfunction

   task automatic pool_relink();
      int unsigned n;
      n = eff_count();
      for (int i = 0; i < POOL_SLOTS; i++)
         next_free[i] = (i + 1 < n) ? 9'(i + 1) : 9'(POOL_SLOTS);
      free_head   = '0;
      live_blocks = '0;
   endtask

   task automatic pool_step(input pool_req_type rq, output pool_rsp_type rs);
      logic [ADDR_PORT_W-1:0] offset;
      logic [63:0]            span;
      logic [BLK_W-1:0]       blk;
      int unsigned            slot;
      rs  = '0;
      blk = eff_block();
      case (rq.operation)
         OP_ALLOC: begin
            if (free_head >= POOL_SLOTS) begin
               rs.status = STATUS_EXHAUSTED;
            end else begin
               rs.block_address = cfg_base + ADDR_PORT_W'(free_head) * ADDR_PORT_W'(blk);
               free_head = next_free[free_head];
               if (live_blocks < POOL_SLOTS) live_blocks++;
            end
         end
         OP_FREE: begin
            offset = rq.release_address - cfg_base;
            span   = 64'(blk) * 64'(eff_count());
            if (rq.release_address == '0) begin
               rs.status = STATUS_NULL;
            end else if (64'(offset) >= span) begin
               rs.status = STATUS_RANGE;
            end else if (offset % ADDR_PORT_W'(blk) != 0) begin
               rs.status = STATUS_MISALIGN;
            end else begin
               // push back without any double-free check
               slot = offset / ADDR_PORT_W'(blk);
               next_free[slot] = free_head;
               free_head = 9'(slot);
               if (live_blocks > 0) live_blocks--;
            end
         end
         OP_RESET: pool_relink();
         default: ;
      endcase
      rs.live_count = live_blocks;
   endtask

   task automatic queue_req(input logic [OP_W-1:0] op, input logic [ADDR_PORT_W-1:0] addr);
      pool_req_type rq;
      rq.operation       = op;
      rq.release_address = addr;
      req_backlog.push_back(rq);
      reqs_queued++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_POOL_BASE:     cfg_base  = data;
         REG_BLOCK_BYTES:   cfg_block = data[BLK_W-1:0];
         REG_BLOCKS_IN_USE: cfg_count = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic pool_setup(input logic [CSR_DATA_W-1:0] base,
                             input logic [CSR_DATA_W-1:0] blk,
                             input logic [CSR_DATA_W-1:0] cnt);
      csr_write(REG_POOL_BASE, base);
      csr_write(REG_BLOCK_BYTES, blk);
      csr_write(REG_BLOCKS_IN_USE, cnt);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for every request to be answered, then let the block go quiet
   task automatic settle(input int cycles);
      while (reqs_taken != reqs_queued || due_results.size() != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      int unsigned pick;
      int unsigned k;
      if ($urandom_range(0, 1) == 1) queue_req(OP_RESET, $urandom);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         k    = $urandom_range(0, eff_count() - 1);
         if (pick < 45)
            queue_req(OP_ALLOC, $urandom);
         else if (pick < 80)
            queue_req(OP_FREE, block_at(k));
         else if (pick < 84)
            queue_req(OP_FREE, '0);
         else if (pick < 88)
            queue_req(OP_FREE, ($urandom_range(0, 1) == 1) ?
                      block_at(eff_count() + $urandom_range(0, 3)) :
                      cfg_base - ADDR_PORT_W'($urandom_range(1, 64)));
         else if (pick < 92)
            queue_req(OP_FREE, block_at(k) + ADDR_PORT_W'($urandom_range(1, eff_block() - 1)));
         else if (pick < 95)
            queue_req(OP_FREE, $urandom);
         else if (pick < 98)
            queue_req(OP_RESET, $urandom);
         else
            queue_req(OP_SPARE, $urandom);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] blk_pick;
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = REG_POOL_BASE;
      csr_wdata               = '0;
      reqs_queued             = 0;
      reqs_taken              = 0;
      mismatches              = 0;
      cfg_base                = '0;
      cfg_block               = BLK_RESET;
      cfg_count               = COUNT_RESET;
      pool_relink();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset configuration, every status but exhausted and the unused operation
      queue_req(OP_FREE, '0);
      queue_req(OP_ALLOC, '0);
      queue_req(OP_ALLOC, 32'hFFFF_FFFF);
      queue_req(OP_ALLOC, '0);
      queue_req(OP_FREE, block_at(1));
      queue_req(OP_FREE, block_at(0) + 32'd8);
      queue_req(OP_FREE, block_at(POOL_SLOTS));
      queue_req(OP_FREE, 32'hFFFF_FFF0);
      queue_req(OP_FREE, 32'hFFFF_FFFF);
      queue_req(OP_SPARE, 32'hA5A5_5A5A);
      queue_req(OP_FREE, block_at(1));
      queue_req(OP_ALLOC, '0);
      queue_req(OP_ALLOC, '0);
      queue_req(OP_FREE, block_at(POOL_SLOTS - 1));
      queue_req(OP_RESET, '0);
      queue_req(OP_ALLOC, '0);
      settle(PAUSE_CYCLES);

      // directed: tiny pool, stale list first, then relink and exhaust it
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      pool_setup(32'h0000_1000, 32'd32, 32'd3);
      queue_req(OP_ALLOC, '0);
      queue_req(OP_FREE, block_at(3));
      queue_req(OP_RESET, '0);
      repeat (4) queue_req(OP_ALLOC, '0);
      queue_req(OP_FREE, block_at(1));
      queue_req(OP_FREE, block_at(0) + 32'd16);
      queue_req(OP_FREE, 32'h0000_0FE0);
      queue_req(OP_ALLOC, '0);
      queue_req(OP_FREE, '0);
      settle(PAUSE_CYCLES);

      // block size 65536, addresses wrap past the top
      pool_setup(32'hFFFF_FF00, 32'h0001_0000, 32'd256);
      random_phase(200);
      settle(PAUSE_CYCLES);

      // drain the full pool, double free one block, then run the count to its ceiling
      pool_setup(32'h8000_0000, 32'd16, 32'd256);
      queue_req(OP_RESET, '0);
      repeat (POOL_SLOTS + 1) queue_req(OP_ALLOC, $urandom);
      blk_pick = block_at($urandom_range(0, POOL_SLOTS - 1));
      queue_req(OP_FREE, blk_pick);
      queue_req(OP_FREE, blk_pick);
      repeat (3) queue_req(OP_ALLOC, '0);
      settle(PAUSE_CYCLES);

      // zero size and zero count fall back to the minimums
      pool_setup(32'hFFFF_FFFF, 32'd0, 32'd0);
      random_phase(120);
      settle(PAUSE_CYCLES);

      // stray upper bits in the write data; count above the pool clamps
      pool_setup($urandom, 32'hFFFE_0007, 32'hFFFF_FFFF);
      random_phase(150);
      settle(PAUSE_CYCLES);

      pool_setup(32'h0000_0000, 32'h0001_FFFF, 32'd257);
      random_phase(150);

      for (int p = 0; p < 8; p++) begin
         settle(PAUSE_CYCLES);
         case ($urandom_range(0, 3))
            0:       blk_pick = 32'd16 << $urandom_range(0, 12);
            1:       blk_pick = $urandom_range(16, 65536);
            2:       blk_pick = 32'd16 * $urandom_range(1, 8);
            default: blk_pick = $urandom_range(0, 15);
         endcase
         pool_setup($urandom, blk_pick,
                    ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 256));
         random_phase(120);
      end

      settle(DRAIN_CYCLES);
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // request driver: bursts of random length with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pool_step(req_in_hand, predicted_rsp);
            due_results.push_back(predicted_rsp);
            reqs_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_in_hand = req_backlog.pop_front();
               req_bus.valid           <= 1'b1;
               req_bus.operation       <= req_in_hand.operation;
               req_bus.release_address <= req_in_hand.release_address;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response stalls: rotate a mask, pick a fresh one whenever the 7-bit phase counter wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
         stall_mask  = 16'hFFFF;
         stall_phase = '0;
      end else begin
         if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_mask = 16'hFFFF;
               1:       stall_mask = 16'($urandom) | 16'h0001;
               2:       stall_mask = 16'($urandom & $urandom & $urandom) | 16'h0001;
               default: stall_mask = 16'h00FF;
            endcase
         end
         stall_phase++;
         rsp_bus.ready <= stall_mask[0];
         stall_mask = {stall_mask[0], stall_mask[15:1]};
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected response addr=%h status=%0d live=%0d",
                        rsp_bus.block_address, rsp_bus.status, rsp_bus.live_count);
         end else begin
            oldest_due = due_results.pop_front();
            if (rsp_bus.block_address !== oldest_due.block_address ||
                rsp_bus.status !== oldest_due.status ||
                rsp_bus.live_count !== oldest_due.live_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"tb: response mismatch: expected addr=%h status=%0d live=%0d,",
                            " got addr=%h status=%0d live=%0d"},
                           oldest_due.block_address, oldest_due.status,
                           oldest_due.live_count, rsp_bus.block_address,
                           rsp_bus.status, rsp_bus.live_count);
            end
         end
      end
   end

   // abort when neither channel nor the register port moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: no progress for %0d cycles", QUIET_LIMIT);
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
